// ===== src/spq_pkg.sv =====
// Shared types, constants and lookup functions for the shuangpin to quanpin core.
// Used by the top level and the port checker; depends on nothing.
package spq_pkg;

  localparam logic [7:0] SEP_CHAR = 8'h27;
  localparam logic [7:0] NUL_CHAR = 8'h00;
  localparam logic [1:0] MODE_QP_SEP = 2'd0;
  localparam logic [1:0] MODE_QP_NOSEP = 2'd1;
  localparam logic [1:0] MODE_SHP_SEP = 2'd2;
  localparam logic [1:0] MODE_SHP_ALIAS = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] held_byte;
    logic       held_valid;
    logic       emitted_any;
  } state_t;

  typedef struct packed {
    logic [6:0][7:0] text;
    logic [2:0]      len;
  } seg_t;

  typedef struct packed {
    logic [3:0][7:0] s;
    logic [2:0]      n;
  } fin_t;

  typedef struct packed {
    logic [1:0][7:0] s;
    logic [1:0]      n;
  } ini_t;

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? 8'(c + 8'd32) : c;
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return (c >= "a" && c <= "z");
  endfunction

  function automatic fin_t fin4(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                logic [7:0] c3, logic [2:0] n);
    fin_t f;
    f.s = {c3, c2, c1, c0};
    f.n = n;
    return f;
  endfunction

  // Bit k set means initial key a takes final key "a"+k.
  function automatic logic [25:0] syl_mask(logic [7:0] a);
    logic [25:0] m;
    case (a)
      "a": m = 26'h0004100;
      "b": m = 26'h050F7EF;
      "c": m = 26'h31203FD;
      "d": m = 26'h3D3B7FD;
      "e": m = 26'h0000100;
      "f": m = 26'h25062E1;
      "g": m = 26'h35202FD;
      "h": m = 26'h35202FD;
      "i": m = 26'h31203FD;
      "j": m = 26'h19FBD02;
      "k": m = 26'h35202FD;
      "l": m = 26'h3FBFFDF;
      "m": m = 26'h251F7FF;
      "n": m = 26'h37BBFFF;
      "o": m = 26'h0100000;
      "p": m = 26'h250F7EF;
      "q": m = 26'h19FBD02;
      "r": m = 26'h31203F4;
      "s": m = 26'h31203FD;
      "t": m = 26'h312B7DD;
      "u": m = 26'h35203FD;
      "v": m = 26'h35203FD;
      "w": m = 26'h05042E9;
      "x": m = 26'h19FBD02;
      "y": m = 26'h31A4797;
      "z": m = 26'h35203FD;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic fin_t fin_text(logic [7:0] b);
    fin_t f;
    case (b)
      "a": f = fin4("a", NUL_CHAR, NUL_CHAR, NUL_CHAR, 3'd1);
      "b": f = fin4("i", "n", NUL_CHAR, NUL_CHAR, 3'd2);
      "c": f = fin4("a", "o", NUL_CHAR, NUL_CHAR, 3'd2);
      "d": f = fin4("a", "i", NUL_CHAR, NUL_CHAR, 3'd2);
      "e": f = fin4("e", NUL_CHAR, NUL_CHAR, NUL_CHAR, 3'd1);
      "f": f = fin4("e", "n", NUL_CHAR, NUL_CHAR, 3'd2);
      "g": f = fin4("e", "n", "g", NUL_CHAR, 3'd3);
      "h": f = fin4("a", "n", "g", NUL_CHAR, 3'd3);
      "i": f = fin4("i", NUL_CHAR, NUL_CHAR, NUL_CHAR, 3'd1);
      "j": f = fin4("a", "n", NUL_CHAR, NUL_CHAR, 3'd2);
      "k": f = fin4("i", "n", "g", NUL_CHAR, 3'd3);
      "l": f = fin4("i", "a", "n", "g", 3'd4);
      "m": f = fin4("i", "a", "n", NUL_CHAR, 3'd3);
      "n": f = fin4("i", "a", "o", NUL_CHAR, 3'd3);
      "o": f = fin4("o", NUL_CHAR, NUL_CHAR, NUL_CHAR, 3'd1);
      "p": f = fin4("i", "e", NUL_CHAR, NUL_CHAR, 3'd2);
      "q": f = fin4("i", "u", NUL_CHAR, NUL_CHAR, 3'd2);
      "r": f = fin4("u", "a", "n", NUL_CHAR, 3'd3);
      "s": f = fin4("i", "o", "n", "g", 3'd4);
      "t": f = fin4("v", "e", NUL_CHAR, NUL_CHAR, 3'd2);
      "u": f = fin4("u", NUL_CHAR, NUL_CHAR, NUL_CHAR, 3'd1);
      "v": f = fin4("v", NUL_CHAR, NUL_CHAR, NUL_CHAR, 3'd1);
      "w": f = fin4("e", "i", NUL_CHAR, NUL_CHAR, 3'd2);
      "x": f = fin4("i", "a", NUL_CHAR, NUL_CHAR, 3'd2);
      "y": f = fin4("u", "n", NUL_CHAR, NUL_CHAR, 3'd2);
      "z": f = fin4("o", "u", NUL_CHAR, NUL_CHAR, 3'd2);
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic ini_t init_text(logic [7:0] a);
    ini_t r;
    case (a)
      "u": begin r.s = {"h", "s"}; r.n = 2'd2; end
      "i": begin r.s = {"h", "c"}; r.n = 2'd2; end
      "v": begin r.s = {"h", "z"}; r.n = 2'd2; end
      default: begin r.s = {NUL_CHAR, a}; r.n = 2'd1; end
    endcase
    return r;
  endfunction

  function automatic seg_t seg3(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                logic [2:0] n);
    seg_t s;
    s = '0;
    s.text[0] = c0;
    s.text[1] = c1;
    s.text[2] = c2;
    s.len = n;
    return s;
  endfunction

  // Quanpin of a key pair; length zero when the pair is not a syllable.
  function automatic seg_t pair_text(logic [7:0] a, logic [7:0] b);
    seg_t s;
    fin_t f;
    ini_t ini;
    logic [4:0] bi;
    logic [25:0] m;
    int ni;
    int j;
    s = '0;
    f = fin_text(b);
    ini = init_text(a);
    ni = int'(ini.n);
    bi = 5'(b - 8'h61);
    m = syl_mask(a);
    case ({a, b})
      "aa": s = seg3("a", NUL_CHAR, NUL_CHAR, 3'd1);
      "ai": s = seg3("a", "i", NUL_CHAR, 3'd2);
      "an": s = seg3("a", "n", NUL_CHAR, 3'd2);
      "ao": s = seg3("a", "o", NUL_CHAR, 3'd2);
      "ah": s = seg3("a", "n", "g", 3'd3);
      "ee": s = seg3("e", NUL_CHAR, NUL_CHAR, 3'd1);
      "ei": s = seg3("e", "i", NUL_CHAR, 3'd2);
      "en": s = seg3("e", "n", NUL_CHAR, 3'd2);
      "eg": s = seg3("e", "n", "g", 3'd3);
      "er": s = seg3("e", "r", NUL_CHAR, 3'd2);
      "oo": s = seg3("o", NUL_CHAR, NUL_CHAR, 3'd1);
      "ou": s = seg3("o", "u", NUL_CHAR, 3'd2);
      default: begin
        if (is_lower(b) && m[bi]) begin
          for (int k = 0; k < 6; k++) begin
            j = k - ni;
            if (k < ni) begin
              s.text[3'(k)] = ini.s[1'(k)];
            end else if (j < 4) begin
              s.text[3'(k)] = f.s[2'(j)];
            end
          end
          s.len = 3'(ni) + f.n;
        end
      end
    endcase
    return s;
  endfunction

  function automatic seg_t single_text(logic [7:0] c, logic raw);
    seg_t s;
    ini_t ini;
    s = '0;
    ini = init_text(c);
    if (raw) begin
      s.text[0] = c;
      s.len = 3'd1;
    end else if (c != SEP_CHAR) begin
      s.text[0] = ini.s[0];
      s.text[1] = ini.s[1];
      s.len = 3'(ini.n);
    end
    return s;
  endfunction

  function automatic seg_t with_sep(seg_t s, logic sep);
    seg_t r;
    r = s;
    if (sep) begin
      r.text[0] = SEP_CHAR;
      for (int k = 1; k < 7; k++) begin
        r.text[3'(k)] = s.text[3'(k - 1)];
      end
      r.len = 3'(s.len + 3'd1);
    end
    return r;
  endfunction

endpackage

// ===== src/shuangpin_segment_to_quanpin_core.sv =====
// Shuangpin segmenter and quanpin converter, top level.
// Depends on spq_pkg and spq_ram.
//
// Bytes of a string enter one per beat and leave as quanpin or shuangpin segment text,
// one byte per output beat. An accepted item is registered and decoded, and its output
// bytes, up to six, are loaded into a burst register once it is empty or sending its
// last byte; they are then sent one per cycle while out_ready is high. The next item is
// taken while the burst drains.
// The segmenter state sits in a one-entry RAM with a registered read; a state written
// back in the cycle of the next read is forwarded.
module shuangpin_segment_to_quanpin_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_beat_t out_beat,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data
);

  localparam int StW = $bits(spq_pkg::state_t);

  logic [1:0] mode_r;

  logic              s1_valid_r;
  spq_pkg::in_beat_t s1_beat_r;
  logic              fwd_sel_r;
  spq_pkg::state_t   fwd_state_r;
  logic              ram_init_r;
  logic [StW-1:0]    ram_rdata;

  logic [6:0][7:0] burst_text_r;
  logic [2:0]      burst_len_r;
  logic [2:0]      burst_idx_r;
  logic            burst_last_r;
  logic            burst_valid_r;

  logic            in_fire;
  logic            burst_done;
  logic            s1_move;
  spq_pkg::state_t st;
  spq_pkg::state_t st_nxt;
  spq_pkg::seg_t   seg_a;
  spq_pkg::seg_t   seg_b;
  spq_pkg::seg_t   pair;
  spq_pkg::seg_t   single_a;
  logic [6:0][7:0] text_nxt;
  logic [2:0]      len_nxt;
  logic [7:0]      c;
  logic            raw;
  logic            sep_ok;
  logic            a_emit;
  int              j;

  assign in_fire    = in_valid && in_ready;
  assign burst_done = burst_valid_r && out_ready && (burst_idx_r == burst_len_r - 3'd1);
  assign s1_move    = s1_valid_r && (!burst_valid_r || burst_done);
  assign in_ready   = !s1_valid_r || s1_move;

  spq_ram #(.WIDTH(StW), .DEPTH(1)) u_state_ram (
    .clk   (clk),
    .we    (s1_move),
    .waddr (1'b0),
    .wdata (st_nxt),
    .re    (in_fire),
    .raddr (1'b0),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (fwd_sel_r) begin
      st = fwd_state_r;
    end else if (ram_init_r) begin
      st = spq_pkg::state_t'(ram_rdata);
    end else begin
      st = '0;
    end
  end

  always_comb begin
    c        = spq_pkg::fold(s1_beat_r.char_code);
    raw      = (mode_r >= spq_pkg::MODE_SHP_SEP);
    sep_ok   = (mode_r != spq_pkg::MODE_QP_NOSEP);
    pair     = spq_pkg::pair_text(st.held_byte, c);
    single_a = spq_pkg::single_text(st.held_byte, raw);
    seg_a    = '0;
    seg_b    = '0;
    a_emit   = 1'b0;
    st_nxt   = st;
    if (st.held_valid) begin
      if (pair.len != 3'd0) begin
        if (raw) begin
          seg_a = spq_pkg::seg3(st.held_byte, c, spq_pkg::NUL_CHAR, 3'd2);
        end else begin
          seg_a = pair;
        end
        a_emit = 1'b1;
        st_nxt.held_valid = 1'b0;
        st_nxt.held_byte  = '0;
      end else begin
        seg_a  = single_a;
        a_emit = (single_a.len != 3'd0);
        st_nxt.held_byte = c;
      end
    end else begin
      st_nxt.held_byte  = c;
      st_nxt.held_valid = 1'b1;
    end
    seg_a = spq_pkg::with_sep(seg_a, a_emit && sep_ok && st.emitted_any);
    if (a_emit) begin
      st_nxt.emitted_any = 1'b1;
    end
    if (s1_beat_r.end_of_string) begin
      if (st_nxt.held_valid) begin
        seg_b = spq_pkg::single_text(st_nxt.held_byte, raw);
        seg_b = spq_pkg::with_sep(seg_b,
                                  (seg_b.len != 3'd0) && sep_ok && st_nxt.emitted_any);
      end
      st_nxt = '0;
    end
    if (!a_emit) begin
      seg_a.len = 3'd0;
    end
    for (int k = 0; k < 7; k++) begin
      j = k - int'(seg_a.len);
      if (k < int'(seg_a.len)) begin
        text_nxt[3'(k)] = seg_a.text[3'(k)];
      end else if (j < 7) begin
        text_nxt[3'(k)] = seg_b.text[3'(j)];
      end else begin
        text_nxt[3'(k)] = '0;
      end
    end
    len_nxt = 3'(seg_a.len + seg_b.len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= spq_pkg::MODE_QP_SEP;
      s1_valid_r    <= 1'b0;
      fwd_sel_r     <= 1'b0;
      ram_init_r    <= 1'b0;
      burst_valid_r <= 1'b0;
      burst_idx_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_sel_r  <= s1_move;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        ram_init_r    <= 1'b1;
        burst_valid_r <= (len_nxt != 3'd0);
        burst_idx_r   <= '0;
      end else if (burst_done) begin
        burst_valid_r <= 1'b0;
        burst_idx_r   <= '0;
      end else if (burst_valid_r && out_ready) begin
        burst_idx_r <= 3'(burst_idx_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_beat_r <= in_beat;
    end
    if (s1_move) begin
      fwd_state_r  <= st_nxt;
      burst_text_r <= text_nxt;
      burst_len_r  <= len_nxt;
      burst_last_r <= s1_beat_r.end_of_string;
    end
  end

  assign out_valid         = burst_valid_r;
  assign out_beat.out_char = burst_text_r[burst_idx_r];
  assign out_beat.out_last = burst_last_r && (burst_idx_r == burst_len_r - 3'd1);

endmodule

// ===== src/spq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/spq_checker.sv =====
// Port-level checker for the shuangpin to quanpin core, bound to the top level.
// Depends on spq_pkg and shuangpin_segment_to_quanpin_core.
module spq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input spq_pkg::in_beat_t  in_beat,
  input logic               out_valid,
  input logic               out_ready,
  input spq_pkg::out_beat_t out_beat,
  input logic               cfg_wr_en,
  input logic [1:0]         cfg_wr_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("output beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output appeared without an input beat two cycles before");

  a_ready_when_idle: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled while output side is empty");

endmodule

bind shuangpin_segment_to_quanpin_core spq_checker u_spq_checker (.*);
